[rtl/bfiq_pkg.sv]
// ----------------------------------------------------------------------------
// bfiq_pkg
// Shared constants and the rotate helper for the bloom filter unit
// ----------------------------------------------------------------------------
package bfiq_pkg;

	localparam int FILTER_BITS_DEF = 65536;
	localparam int MAX_PROBES_DEF  = 16;

	localparam logic [31:0] SEED_ONE = 32'h5f3759df;
	localparam logic [31:0] SEED_TWO = 32'h9e3779b9;
	localparam logic [31:0] MIX_C1   = 32'hcc9e2d51;
	localparam logic [31:0] MIX_C2   = 32'h1b873593;
	localparam logic [31:0] MIX_ADD  = 32'he6546b64;
	localparam logic [31:0] FIN_C1   = 32'h85ebca6b;
	localparam logic [31:0] FIN_C2   = 32'hc2b2ae35;

	localparam logic [1:0] CFG_PROBE_COUNT = 2'd0;
	localparam logic [1:0] CFG_FILTER_SIZE = 2'd1;

	localparam logic FUNC_ADD   = 1'b0;
	localparam logic FUNC_CHECK = 1'b1;

	localparam int CFG_W = 17;

	function automatic logic [31:0] rotl(input logic [31:0] v, input int s);
		rotl = (v << s) | (v >> (32 - s));
	endfunction

endpackage

[rtl/bloom_filter_insert_query_unit.sv]
// ----------------------------------------------------------------------------
// bloom_filter_insert_query_unit
// Bloom filter insert and check over murmur3 double hashing
// ----------------------------------------------------------------------------
// channel  signals                                   transfer
// input    func key_word word_bytes last_word        start && !busy
// result   present                                   strobe (one cycle)
// config   cfg_we cfg_index cfg_wdata                cfg_we
//
// a non-last word runs the hash lanes' mix and block steps (full) or is ignored
// (short); a last word runs mix, block and finalize (finalize only when it has
// no bytes), then per probe a 32-step remainder loop, address, read and check,
// then a done step and the strobe; a check miss ends probing early, and a new
// transfer may come with the strobe; after reset a clearing pass runs and busy
// stays high; the receiver cannot stall: present is valid only in the strobe cycle
// ----------------------------------------------------------------------------
module bloom_filter_insert_query_unit #(
	parameter int FILTER_BITS = bfiq_pkg::FILTER_BITS_DEF,
	parameter int MAX_PROBES  = bfiq_pkg::MAX_PROBES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        func,
	input  logic [31:0] key_word,
	input  logic [2:0]  word_bytes,
	input  logic        last_word,
	output logic        strobe,
	output logic        present,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [bfiq_pkg::CFG_W-1:0] cfg_wdata
);
	logic [4:0]  probe_q;
	logic [16:0] size_q;
	logic        func_q;
	logic        hbusy, hdone, pbusy, go;
	logic [31:0] h1, h2;

	assign busy = hbusy || pbusy || hdone;
	assign go = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			probe_q <= 5'd2;
			size_q <= 17'd65536;
		end else if (cfg_we) begin
			if (cfg_index == bfiq_pkg::CFG_PROBE_COUNT) probe_q <= cfg_wdata[4:0];
			else if (cfg_index == bfiq_pkg::CFG_FILTER_SIZE) size_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk) if (go) func_q <= func;

	bfiq_hash u_hash (
		.clk(clk), .arst_n(arst_n), .go(go), .key_word(key_word),
		.word_bytes(word_bytes), .last_word(last_word),
		.busy(hbusy), .done(hdone), .h1(h1), .h2(h2)
	);

	bfiq_probe #(.FILTER_BITS(FILTER_BITS), .MAX_PROBES(MAX_PROBES)) u_probe (
		.clk(clk), .arst_n(arst_n), .go(hdone), .func(func_q), .h1(h1), .h2(h2),
		.probe_count(probe_q), .filter_size(size_q),
		.busy(pbusy), .strobe(strobe), .present(present)
	);

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		hdone |-> !pbusy) else $error("probe busy at hash done");
	a_probe_starts: assert property (@(posedge clk) disable iff (!arst_n)
		hdone |=> pbusy) else $error("probe did not start");
	a_strobe_idle: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> !busy) else $error("busy during result strobe");
endmodule

[rtl/bfiq_ram.sv]
// ----------------------------------------------------------------------------
// bfiq_ram
// Generic single-port synchronous RAM with registered read
// ----------------------------------------------------------------------------
module bfiq_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[addr] <= wdata;
		rdata <= mem[addr];
	end
endmodule

[rtl/bfiq_hash.sv]
// ----------------------------------------------------------------------------
// bfiq_hash
// Two-lane murmur3 accumulator and finalizer, one multiply per cycle per lane
// ----------------------------------------------------------------------------
module bfiq_hash (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        go,
	input  logic [31:0] key_word,
	input  logic [2:0]  word_bytes,
	input  logic        last_word,
	output logic        busy,
	output logic        done,
	output logic [31:0] h1,
	output logic [31:0] h2
);
	// steps: 0 idle, 1 w*c1/rot, 2 rot*c2/xor/rot, 3 mul5, 4 fin mul1, 5 fin mul2, 6 out
	localparam logic [2:0] S_IDLE = 3'd0, S_M1 = 3'd1, S_M2 = 3'd2, S_BLK = 3'd3,
		S_F1 = 3'd4, S_F2 = 3'd5, S_FO = 3'd6;

	logic [2:0]  st_q;
	logic [31:0] ha_q, hb_q, len_q, w_q, t_q, fa_q, fb_q;
	logic        full_q, last_q;
	logic [2:0]  nb;
	logic [31:0] mask, sc, pa, pb;

	assign nb = word_bytes[2] ? 3'd4 : word_bytes;
	always_comb begin
		case (nb)
			3'd1:    mask = 32'h000000ff;
			3'd2:    mask = 32'h0000ffff;
			3'd3:    mask = 32'h00ffffff;
			default: mask = 32'hffffffff;
		endcase
	end
	assign sc = t_q * bfiq_pkg::MIX_C2;

	// fold the first finalize xor into the last block cycle
	assign pa = (full_q ? (ha_q * 32'd5 + bfiq_pkg::MIX_ADD) : ha_q) ^ len_q;
	assign pb = (full_q ? (hb_q * 32'd5 + bfiq_pkg::MIX_ADD) : hb_q) ^ len_q;

	assign busy = st_q != S_IDLE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			ha_q <= bfiq_pkg::SEED_ONE;
			hb_q <= bfiq_pkg::SEED_TWO;
			len_q <= '0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			case (st_q)
				S_IDLE: if (go) begin
					w_q <= key_word & mask;
					full_q <= nb == 3'd4;
					last_q <= last_word;
					if (nb == 3'd4 || (last_word && nb != 3'd0)) begin
						len_q <= len_q + {29'd0, nb};
						st_q <= S_M1;
					end else if (last_word) begin
						st_q <= S_F1;
						fa_q <= (ha_q ^ len_q) ^ ((ha_q ^ len_q) >> 16);
						fb_q <= (hb_q ^ len_q) ^ ((hb_q ^ len_q) >> 16);
					end
				end
				S_M1: begin
					t_q <= bfiq_pkg::rotl(w_q * bfiq_pkg::MIX_C1, 15);
					st_q <= S_M2;
				end
				S_M2: begin
					if (full_q) begin
						ha_q <= bfiq_pkg::rotl(ha_q ^ sc, 13);
						hb_q <= bfiq_pkg::rotl(hb_q ^ sc, 13);
					end else begin
						ha_q <= ha_q ^ sc;
						hb_q <= hb_q ^ sc;
					end
					st_q <= S_BLK;
				end
				S_BLK: begin
					if (full_q) begin
						ha_q <= ha_q * 32'd5 + bfiq_pkg::MIX_ADD;
						hb_q <= hb_q * 32'd5 + bfiq_pkg::MIX_ADD;
					end
					if (last_q) begin
						fa_q <= pa ^ (pa >> 16);
						fb_q <= pb ^ (pb >> 16);
						st_q <= S_F1;
					end else st_q <= S_IDLE;
				end
				S_F1: begin
					fa_q <= fa_q * bfiq_pkg::FIN_C1;
					fb_q <= fb_q * bfiq_pkg::FIN_C1;
					st_q <= S_F2;
				end
				S_F2: begin
					fa_q <= (fa_q ^ (fa_q >> 13)) * bfiq_pkg::FIN_C2;
					fb_q <= (fb_q ^ (fb_q >> 13)) * bfiq_pkg::FIN_C2;
					st_q <= S_FO;
				end
				S_FO: begin
					h1 <= fa_q ^ (fa_q >> 16);
					h2 <= fb_q ^ (fb_q >> 16);
					done <= 1'b1;
					ha_q <= bfiq_pkg::SEED_ONE;
					hb_q <= bfiq_pkg::SEED_TWO;
					len_q <= '0;
					st_q <= S_IDLE;
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	property p_done_idle;
		@(posedge clk) disable iff (!arst_n) done |-> st_q == S_IDLE;
	endproperty
	a_done_idle: assert property (p_done_idle) else $error("done outside idle");
	a_seed_back: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ha_q == bfiq_pkg::SEED_ONE && len_q == '0)
		else $error("hash not restarted");
	a_go_idle: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(go))
		else $error("hash started without go");
endmodule

[rtl/bfiq_probe.sv]
// ----------------------------------------------------------------------------
// bfiq_probe
// Probe sequencer: index by remainder unit, read-modify-write of the bit store
// ----------------------------------------------------------------------------
module bfiq_probe #(
	parameter int FILTER_BITS = bfiq_pkg::FILTER_BITS_DEF,
	parameter int MAX_PROBES  = bfiq_pkg::MAX_PROBES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        go,
	input  logic        func,
	input  logic [31:0] h1,
	input  logic [31:0] h2,
	input  logic [4:0]  probe_count,
	input  logic [16:0] filter_size,
	output logic        busy,
	output logic        strobe,
	output logic        present
);
	localparam int AW = $clog2(FILTER_BITS);
	localparam int MW = AW + 1;

	localparam logic [2:0] P_IDLE = 3'd0, P_CLR = 3'd1, P_DIV = 3'd2, P_RD = 3'd3,
		P_WT = 3'd4, P_CHK = 3'd5, P_DONE = 3'd6;

	logic [2:0]    st_q;
	logic [AW:0]   clr_q;
	logic [31:0]   acc_q, h2_q;
	logic [6:0]    left_q;
	logic [MW-1:0] m_q;
	logic [31:0]   rem_q;
	logic [5:0]    bit_q;
	logic [AW-1:0] idx_q;
	logic          func_q, hit_q;
	logic          we;
	logic [AW-1:0] addr;
	logic          rd;
	logic [32:0]   trial;
	logic [31:0]   rem_sh;
	logic [6:0]    kq;
	logic [MW-1:0] mq;

	always_comb begin
		kq = {2'd0, probe_count};
		if (kq > 7'(MAX_PROBES)) kq = 7'(MAX_PROBES);
		if (filter_size == 17'd0) mq = MW'(1);
		else if (32'(filter_size) > 32'(FILTER_BITS)) mq = MW'(FILTER_BITS);
		else mq = MW'(filter_size);
	end

	// restoring remainder, one bit per cycle
	assign rem_sh = {rem_q[30:0], acc_q[5'(bit_q)]};
	assign trial = {1'b0, rem_sh} - {{(33-MW){1'b0}}, m_q};

	assign busy = st_q != P_IDLE;
	assign we = (st_q == P_CLR) || (st_q == P_CHK && !func_q);
	assign addr = (st_q == P_CLR) ? clr_q[AW-1:0] : idx_q;

	bfiq_ram #(.WIDTH(1), .DEPTH(FILTER_BITS)) u_bits (
		.clk(clk), .we(we), .addr(addr), .wdata(st_q != P_CLR), .rdata(rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= P_CLR;
			clr_q <= '0;
			strobe <= 1'b0;
		end else begin
			strobe <= 1'b0;
			case (st_q)
				P_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == (AW+1)'(FILTER_BITS - 1)) st_q <= P_IDLE;
				end
				P_IDLE: if (go) begin
					acc_q <= h1; h2_q <= h2; func_q <= func; hit_q <= 1'b1;
					left_q <= kq; m_q <= mq;
					rem_q <= '0; bit_q <= 6'd31;
					st_q <= (kq == 7'd0) ? P_DONE : P_DIV;
				end
				P_DIV: begin
					rem_q <= trial[32] ? rem_sh : trial[31:0];
					if (bit_q == 6'd0) st_q <= P_RD;
					else bit_q <= bit_q - 1'b1;
				end
				P_RD: begin
					idx_q <= AW'(rem_q);
					st_q <= P_WT;
				end
				P_WT: st_q <= P_CHK;
				P_CHK: begin
					if (func_q == bfiq_pkg::FUNC_CHECK && !rd) begin
						hit_q <= 1'b0; st_q <= P_DONE;
					end else if (left_q == 7'd1) st_q <= P_DONE;
					else begin
						left_q <= left_q - 1'b1;
						acc_q <= acc_q + h2_q;
						rem_q <= '0; bit_q <= 6'd31;
						st_q <= P_DIV;
					end
				end
				P_DONE: begin
					strobe <= 1'b1; present <= hit_q; st_q <= P_IDLE;
				end
				default: st_q <= P_IDLE;
			endcase
		end
	end

	a_rem_lt: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == P_RD |-> rem_q < 32'(m_q)) else $error("remainder out of range");
	a_add_hit: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !func_q |-> present) else $error("add reported absent");
	a_no_go_clr: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == P_CLR |-> busy) else $error("clear not busy");
endmodule

[test/tb_bloom_filter_insert_query_unit.sv]
// ----------------------------------------------------------------------------
// tb_bloom_filter_insert_query_unit
// Random and directed key words through the bloom filter unit, with a
// scoreboard that hashes each key itself and tracks its own copy of the filter
// ----------------------------------------------------------------------------
module tb_bloom_filter_insert_query_unit;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NBITS = 65536;
	localparam int NPROBES = 16;
	localparam longint CYCLE_LIMIT = 64'd40000000;

	class bloom_scoreboard;
		bit filter_store [NBITS];
		logic [31:0] acc_one, acc_two, byte_total;
		logic [4:0] probes;
		logic [16:0] size_cfg;
		bit expected_present [$];
		int mismatches;

		function void clear_key();
			acc_one = bfiq_pkg::SEED_ONE;
			acc_two = bfiq_pkg::SEED_TWO;
			byte_total = 0;
		endfunction

		function void init();
			foreach (filter_store[i]) filter_store[i] = 0;
			clear_key();
			probes = 5'd2;
			size_cfg = 17'd65536;
			mismatches = 0;
		endfunction

		function void note_config(logic [1:0] idx, logic [16:0] val);
			if (idx == bfiq_pkg::CFG_PROBE_COUNT) probes = val[4:0];
			else if (idx == bfiq_pkg::CFG_FILTER_SIZE) size_cfg = val;
		endfunction

		function logic [31:0] rot(logic [31:0] v, int s);
			return (v << s) | (v >> (32 - s));
		endfunction

		function logic [31:0] mix_word(logic [31:0] w);
			w = w * bfiq_pkg::MIX_C1;
			w = rot(w, 15);
			return w * bfiq_pkg::MIX_C2;
		endfunction

		function logic [31:0] fold_word(logic [31:0] h, logic [31:0] w);
			h = h ^ mix_word(w);
			h = rot(h, 13);
			return h * 32'd5 + bfiq_pkg::MIX_ADD;
		endfunction

		function logic [31:0] avalanche(logic [31:0] h, logic [31:0] len);
			h = h ^ len;
			h = h ^ (h >> 16);
			h = h * bfiq_pkg::FIN_C1;
			h = h ^ (h >> 13);
			h = h * bfiq_pkg::FIN_C2;
			h = h ^ (h >> 16);
			return h;
		endfunction

		// returns 1 when this word produces a result
		function bit note_word(logic op, logic [31:0] w, logic [2:0] nb, logic last);
			logic [31:0] h1, h2, m, k, idx, tail;
			int n;
			bit hit;
			n = (nb > 4) ? 4 : nb;
			hit = 1;
			if (n == 4) begin
				acc_one = fold_word(acc_one, w);
				acc_two = fold_word(acc_two, w);
				byte_total = byte_total + 4;
			end else if (last && n > 0) begin
				tail = w & ((32'd1 << (8 * n)) - 1);
				acc_one = acc_one ^ mix_word(tail);
				acc_two = acc_two ^ mix_word(tail);
				byte_total = byte_total + n;
			end
			if (!last) return 0;
			h1 = avalanche(acc_one, byte_total);
			h2 = avalanche(acc_two, byte_total);
			clear_key();
			m = (size_cfg == 0) ? 1 : ((size_cfg > NBITS) ? NBITS : size_cfg);
			k = (probes > NPROBES) ? NPROBES : probes;
			for (int i = 0; i < k; i++) begin
				idx = (h1 + i * h2) % m;
				if (op == bfiq_pkg::FUNC_ADD) filter_store[idx] = 1;
				else if (!filter_store[idx]) begin
					hit = 0;
					break;
				end
			end
			expected_present.push_back(hit);
			return 1;
		endfunction

		function void check_result(logic got);
			bit want;
			if (expected_present.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result present=%b", got);
				return;
			end
			want = expected_present.pop_front();
			if (got !== want) begin
				mismatches++;
				if (mismatches <= 10) $display("present mismatch: expected %b got %b", want, got);
			end
		endfunction
	endclass

	logic clk, arst_n, start, busy, func, last_word, strobe, present, cfg_we;
	logic [31:0] key_word;
	logic [2:0] word_bytes;
	logic [1:0] cfg_index;
	logic [bfiq_pkg::CFG_W-1:0] cfg_wdata;

	bloom_scoreboard board;
	int gap_pct;
	longint cycles;

	bloom_filter_insert_query_unit dut (.*);

	always begin
		clk = 1'b0; #5;
		clk = 1'b1; #5;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb_bloom_filter_insert_query_unit: FAIL");
			$finish;
		end
	end

	always @(posedge clk) if (arst_n && strobe) board.check_result(present);

	task automatic send_word(logic op, logic [31:0] w, logic [2:0] nb, logic last);
		while ($urandom_range(99) < gap_pct) @(negedge clk);
		func = op;
		key_word = w;
		word_bytes = nb;
		last_word = last;
		start = 1'b1;
		do @(posedge clk); while (busy);
		void'(board.note_word(op, w, nb, last));
		@(negedge clk);
		start = 1'b0;
	endtask

	task automatic drain();
		while (board.expected_present.size() != 0) @(negedge clk);
		repeat (60) @(negedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [16:0] val);
		cfg_index = idx;
		cfg_wdata = val;
		cfg_we = 1'b1;
		@(posedge clk);
		board.note_config(idx, val);
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	// random key of a few words, op on the last word; some short non-last noise
	task automatic send_key(logic op);
		int len;
		len = $urandom_range(3);
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(9) == 0)
				send_word(1'($urandom_range(1)), $urandom, 3'($urandom_range(3)), 1'b0);
			send_word(1'($urandom_range(1)), $urandom, 3'(($urandom_range(3) == 0) ?
				$urandom_range(7, 4) : 4), 1'b0);
		end
		send_word(op, $urandom, 3'($urandom_range(7)), 1'b1);
	endtask

	// adds a few keys and checks each right after (hits), among random adds and checks
	task automatic random_phase(int n_keys);
		logic [31:0] keep [$];
		logic [2:0] kb;
		for (int i = 0; i < n_keys; i++) begin
			if ($urandom_range(3) == 0) begin
				keep.push_back($urandom);
				kb = 3'($urandom_range(4));
				send_word(bfiq_pkg::FUNC_ADD, keep[$], kb, 1'b1);
				send_word(bfiq_pkg::FUNC_CHECK, keep[$], kb, 1'b1);
			end else send_key(1'($urandom_range(1)));
		end
	endtask

	initial begin
		board = new();
		board.init();
		cycles = 0;
		arst_n = 1'b0;
		start = 1'b0;
		func = bfiq_pkg::FUNC_ADD;
		key_word = '0;
		word_bytes = '0;
		last_word = 1'b0;
		cfg_we = 1'b0;
		cfg_index = bfiq_pkg::CFG_PROBE_COUNT;
		cfg_wdata = '0;
		gap_pct = 0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: field extremes, empty key, byte counts, op mixing
		send_word(bfiq_pkg::FUNC_CHECK, 32'h0, 3'd0, 1'b1);
		send_word(bfiq_pkg::FUNC_ADD, 32'h0, 3'd0, 1'b1);
		send_word(bfiq_pkg::FUNC_CHECK, 32'h0, 3'd0, 1'b1);
		send_word(bfiq_pkg::FUNC_ADD, 32'hffffffff, 3'd4, 1'b0);
		send_word(bfiq_pkg::FUNC_ADD, 32'hffffffff, 3'd2, 1'b0);
		send_word(bfiq_pkg::FUNC_CHECK, 32'hffffffff, 3'd7, 1'b0);
		send_word(bfiq_pkg::FUNC_ADD, 32'h12345678, 3'd3, 1'b1);
		send_word(bfiq_pkg::FUNC_CHECK, 32'hffffffff, 3'd4, 1'b0);
		send_word(bfiq_pkg::FUNC_CHECK, 32'hffffffff, 3'd4, 1'b0);
		send_word(bfiq_pkg::FUNC_CHECK, 32'h12345678, 3'd3, 1'b1);
		send_word(bfiq_pkg::FUNC_ADD, 32'ha5a5a5a5, 3'd5, 1'b1);
		send_word(bfiq_pkg::FUNC_CHECK, 32'ha5a5a5a5, 3'd4, 1'b1);
		send_word(bfiq_pkg::FUNC_CHECK, 32'h5a5a5a5a, 3'd1, 1'b1);
		send_word(bfiq_pkg::FUNC_CHECK, 32'h5a5a5a5a, 3'd6, 1'b1);
		drain();

		write_reg(bfiq_pkg::CFG_PROBE_COUNT, 17'd0);
		write_reg(bfiq_pkg::CFG_FILTER_SIZE, 17'd0);
		send_word(bfiq_pkg::FUNC_ADD, 32'h1, 3'd1, 1'b1);
		send_word(bfiq_pkg::FUNC_CHECK, 32'h2, 3'd1, 1'b1);
		drain();
		write_reg(bfiq_pkg::CFG_PROBE_COUNT, 17'h1f);
		send_word(bfiq_pkg::FUNC_CHECK, 32'h3, 3'd4, 1'b1);
		send_word(bfiq_pkg::FUNC_ADD, 32'h3, 3'd4, 1'b1);
		drain();
		write_reg(bfiq_pkg::CFG_FILTER_SIZE, 17'h1ffff);
		write_reg(bfiq_pkg::CFG_PROBE_COUNT, 17'd16);
		send_word(bfiq_pkg::FUNC_ADD, 32'hdeadbeef, 3'd4, 1'b1);
		send_word(bfiq_pkg::FUNC_CHECK, 32'hdeadbeef, 3'd4, 1'b1);
		drain();

		// random phases over several settings, pause until empty between them
		write_reg(bfiq_pkg::CFG_PROBE_COUNT, 17'd1);
		write_reg(bfiq_pkg::CFG_FILTER_SIZE, 17'd64);
		gap_pct = 35;
		random_phase(110);
		drain();
		write_reg(bfiq_pkg::CFG_PROBE_COUNT, 17'd4);
		write_reg(bfiq_pkg::CFG_FILTER_SIZE, 17'd1);
		gap_pct = 52;
		random_phase(90);
		drain();
		write_reg(bfiq_pkg::CFG_PROBE_COUNT, 17'd3);
		write_reg(bfiq_pkg::CFG_FILTER_SIZE, 17'd65536);
		gap_pct = 0;
		random_phase(110);
		drain();
		write_reg(bfiq_pkg::CFG_PROBE_COUNT, 17'd7);
		write_reg(bfiq_pkg::CFG_FILTER_SIZE, 17'd1000);
		random_phase(90);
		drain();

		if (board.mismatches == 0 && board.expected_present.size() == 0)
			$display("tb_bloom_filter_insert_query_unit: PASS");
		else
			$display("tb_bloom_filter_insert_query_unit: FAIL");
		$finish;
	end
endmodule
